FILE: rtl/core/hmf_pkg.sv
package hmf_pkg;

	localparam int VALUE_BITS   = 14;
	localparam int COUNT_BITS   = 12;
	localparam int HIST_DEPTH   = 2 ** VALUE_BITS;
	localparam int S_TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
	localparam int M_TDATA_BITS = ((VALUE_BITS + COUNT_BITS + 7) / 8) * 8;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic                  last;
		logic [VALUE_BITS-1:0] value;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} beat_t;

endpackage

FILE: rtl/core/hmf_ram.sv
module hmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/hmf_front.sv
module hmf_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [hmf_pkg::S_TDATA_BITS-1:0]  s_tdata,  // [VALUE_BITS-1:0] sample_value
	input  logic                              s_tlast,  // is_last
	output hmf_pkg::beat_t                    push,
	input  logic                              q_full
);

	logic           hold_vld_q;
	hmf_pkg::item_t hold_item_q;

	assign s_tready   = !hold_vld_q || !q_full;
	assign push.valid = hold_vld_q && !q_full;
	assign push.item  = hold_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
		end else if (s_tready) begin
			hold_vld_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			hold_item_q.value <= s_tdata[hmf_pkg::VALUE_BITS-1:0];
			hold_item_q.last  <= s_tlast;
		end
	end

endmodule

FILE: rtl/core/hmf_queue.sv
module hmf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  hmf_pkg::beat_t push,
	output logic           full,
	output hmf_pkg::beat_t head,
	input  logic           pop
);

	hmf_pkg::item_t                entries_q [hmf_pkg::QUEUE_DEPTH];
	logic [hmf_pkg::QPTR_BITS-1:0] wr_ptr_q;
	logic [hmf_pkg::QPTR_BITS-1:0] rd_ptr_q;
	logic [hmf_pkg::QPTR_BITS:0]   count_q;

	assign full       = (count_q == (hmf_pkg::QPTR_BITS+1)'(hmf_pkg::QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.item  = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == (hmf_pkg::QPTR_BITS)'(hmf_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == (hmf_pkg::QPTR_BITS)'(hmf_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.valid && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entries_q[wr_ptr_q] <= push.item;
		end
	end

endmodule

FILE: rtl/core/hmf_back.sv
module hmf_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hmf_pkg::beat_t                    head,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [hmf_pkg::M_TDATA_BITS-1:0]  m_tdata
);

	localparam int VB = hmf_pkg::VALUE_BITS;
	localparam int CB = hmf_pkg::COUNT_BITS;

	logic           clearing_q;
	logic [VB-1:0]  clr_addr_q;
	logic           s1_vld_q;
	hmf_pkg::item_t s1_item_q;
	logic [CB-1:0]  best_cnt_q;
	logic [VB-1:0]  best_val_q;
	logic           prev_we_q;
	logic [VB-1:0]  prev_addr_q;
	logic [CB-1:0]  prev_data_q;
	logic           out_vld_q;
	logic [VB-1:0]  out_val_q;
	logic [CB-1:0]  out_cnt_q;

	logic          we;
	logic [VB-1:0] waddr;
	logic [CB-1:0] wdata;
	logic [CB-1:0] rd_data;
	logic [CB-1:0] cur_cnt;
	logic [CB-1:0] new_cnt;
	logic          take;
	logic [CB-1:0] nb_cnt;
	logic [VB-1:0] nb_val;
	logic          s1_last;

	assign s1_last = s1_vld_q && s1_item_q.last;

	assign pop = head.valid && !clearing_q && !s1_last && (!head.item.last || !out_vld_q);

	hmf_ram #(
		.WIDTH(CB),
		.DEPTH(hmf_pkg::HIST_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(head.item.value),
		.rdata(rd_data)
	);

	// forward the write issued in the same cycle as this item's read
	assign cur_cnt = (prev_we_q && prev_addr_q == s1_item_q.value) ? prev_data_q : rd_data;
	assign new_cnt = (cur_cnt == hmf_pkg::COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
	assign take    = (new_cnt > best_cnt_q) ||
		(new_cnt == best_cnt_q && s1_item_q.value < best_val_q);
	assign nb_cnt  = take ? new_cnt : best_cnt_q;
	assign nb_val  = take ? s1_item_q.value : best_val_q;

	assign we    = clearing_q || s1_vld_q;
	assign waddr = clearing_q ? clr_addr_q : s1_item_q.value;
	assign wdata = clearing_q ? '0 : new_cnt;

	assign m_tvalid = out_vld_q;
	assign m_tdata  = (hmf_pkg::M_TDATA_BITS)'({out_cnt_q, out_val_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			s1_vld_q   <= 1'b0;
			best_cnt_q <= '0;
			best_val_q <= '0;
			prev_we_q  <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			s1_vld_q  <= pop;
			prev_we_q <= we;
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == '1) begin
					clearing_q <= 1'b0;
				end
			end else if (s1_last) begin
				clearing_q <= 1'b1;
			end
			if (s1_vld_q) begin
				if (s1_item_q.last) begin
					best_cnt_q <= '0;
					best_val_q <= '0;
				end else begin
					best_cnt_q <= nb_cnt;
					best_val_q <= nb_val;
				end
			end
			if (s1_last) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			s1_item_q <= head.item;
		end
		prev_addr_q <= waddr;
		prev_data_q <= wdata;
		if (s1_last) begin
			out_val_q <= nb_val;
			out_cnt_q <= nb_cnt;
		end
	end

endmodule

FILE: rtl/core/histogram_mode_finder.sv
// A last beat's result goes through the front hold, queue, s1 and output registers.
// Throughput: one beat per cycle within a set while not clearing, set by the histogram
// RAM read-modify-write with one-deep write forwarding.
// After each set's last beat the histogram RAM is cleared one entry a cycle, all of its
// 2^VALUE_BITS entries; the front queue keeps taking beats until it fills.
// Reset (arst_n low, asynchronous): the same clearing pass runs before the first beat.
module histogram_mode_finder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [hmf_pkg::S_TDATA_BITS-1:0]  s_tdata,  // [VALUE_BITS-1:0] sample_value
	input  logic                              s_tlast,  // is_last
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [hmf_pkg::M_TDATA_BITS-1:0]  m_tdata   // mode_value, then mode_count
);

	hmf_pkg::beat_t push;
	hmf_pkg::beat_t head;
	logic           q_full;
	logic           pop;

	hmf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.push    (push),
		.q_full  (q_full)
	);

	hmf_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (q_full),
		.head  (head),
		.pop   (pop)
	);

	hmf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule
